// ----- hw/rtl/voke_pkg.sv -----
// ----------------------------------------------------------------------------
// voke_pkg
// shared types, widths and codes of the variable order k-mer encoder
// ----------------------------------------------------------------------------
package voke_pkg;

    // default bounds of the configuration registers
    localparam int MAX_ORDER_DEF = 8;
    localparam int MAX_RADIX_DEF = 16;

    // field and datapath widths
    localparam int CODE_W  = 33;
    localparam int WIN_W   = 32;
    localparam int LEN_W   = 4;
    localparam int SYM_W   = 4;
    localparam int RADIX_W = 5;
    localparam int MODE_W  = 2;
    localparam int ACC_W   = 34;
    localparam int NIB_CNT = WIN_W / SYM_W;

    // register reset values
    localparam logic [RADIX_W-1:0] RST_RADIX = 5'd4;
    localparam logic [LEN_W-1:0]   RST_ORDER = 4'd3;

    // apb geometry
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_DECODE = 2'd2
    } t_mode;

    // register indexes
    typedef enum logic {
        REG_RADIX = 1'b0,
        REG_ORDER = 1'b1
    } t_reg_idx;

    // request beat
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  base;
        logic [CODE_W-1:0] code_in;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [LEN_W-1:0]  length;
        logic [SYM_W-1:0]  last_base;
        logic [CODE_W-1:0] prefix_code;
        logic [CODE_W-1:0] suffix_code;
        logic              error;
    } t_out_item;

    // sequencer states
    typedef enum logic [3:0] {
        ST_RB_START,
        ST_RB_MUL,
        ST_RB_ADD,
        ST_RB_TOT,
        ST_IDLE,
        ST_SLIDE_MOD,
        ST_PUSH_MUL,
        ST_PUSH_OFF,
        ST_DEC_CHK,
        ST_DEC_LEN,
        ST_DEC_SUB,
        ST_DEC_DIV,
        ST_DEC_PRE,
        ST_DEC_MOD,
        ST_DEC_SUF,
        ST_OUT
    } t_state;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC,
        ALU_DIV
    } t_alu_op;

endpackage

// ----- hw/rtl/voke_stream_if.sv -----
// ----------------------------------------------------------------------------
// voke_stream_if
// valid/ready stream channel carrying one payload beat per handshake
// ----------------------------------------------------------------------------
interface voke_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/variable_order_kmer_encoder_core.sv -----
// ----------------------------------------------------------------------------
// variable_order_kmer_encoder_core: variable order k-mer code encoder/decoder
// push: shift the base in, add the level offset; a sliding push first drops the oldest symbol
// clear, bad base and bad mode go straight to the result; decode: range check (bad code out),
// level search, window value (empty k-mer out), eight radix nibble steps and four remainder steps
// one beat in the sequencer at a time; the next beat is taken in idle, once the result is in the output register
// sync reset, and every register write, rebuilds the level tables
// (request not ready meanwhile) and empties the window
// ----------------------------------------------------------------------------
module variable_order_kmer_encoder_core
    import voke_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    voke_stream_if.sink       i_req,
    voke_stream_if.source     o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(MAX_ORDER + 1);
    localparam int NIB_W = $clog2(NIB_CNT);
    localparam logic [IDX_W-1:0]   IDX_MAX   = IDX_W'(MAX_ORDER);
    localparam logic [NIB_W-1:0]   NIB_LAST  = NIB_W'(NIB_CNT - 1);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [LEN_W-1:0]   ORDER_MAX = LEN_W'(MAX_ORDER);
    localparam logic [LEN_W-1:0]   ORDER_MIN = 4'd1;
    localparam logic [RADIX_W-1:0] RADIX_RST = (RST_RADIX > RADIX_MAX) ? RADIX_MAX : RST_RADIX;
    localparam logic [LEN_W-1:0]   ORDER_RST = (RST_ORDER > ORDER_MAX) ? ORDER_MAX : RST_ORDER;

    // sequencer and configuration
    t_state              r_state, n_state;
    logic [RADIX_W-1:0]  r_radix, n_radix;
    logic [LEN_W-1:0]    r_order, n_order;
    logic [WIN_W-1:0]    r_wv, n_wv;
    logic [LEN_W-1:0]    r_wlen, n_wlen;

    // level tables
    logic [CODE_W-1:0]   r_pow [0:MAX_ORDER];
    logic [CODE_W-1:0]   r_off [0:MAX_ORDER];
    logic [CODE_W-1:0]   r_total, n_total;

    // working registers
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [WIN_W-1:0]    r_quo, n_quo;
    logic [SYM_W-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [NIB_W-1:0]    r_nib, n_nib;
    logic [1:0]          r_bit, n_bit;
    t_in_item            r_item, n_item;
    t_out_item           r_res, n_res;

    // output register
    t_out_item           r_out, n_out;
    logic                r_ovalid, n_ovalid;

    // table access
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [CODE_W-1:0]   rd_pow;
    logic [CODE_W-1:0]   rd_off;
    logic                pow_we;
    logic                off_we;
    logic [CODE_W-1:0]   pow_wdata;
    logic [CODE_W-1:0]   off_wdata;

    // shared unit
    t_alu_op             alu_op;
    logic [ACC_W-1:0]    alu_a;
    logic [ACC_W-1:0]    alu_b;
    logic [ACC_W-1:0]    alu_y;
    logic                alu_borrow;

    // configuration write
    logic                cfg_we;
    logic [RADIX_W-1:0]  cfg_radix;
    logic [LEN_W-1:0]    cfg_order;

    assign rd_pow = r_pow[rd_idx];
    assign rd_off = r_off[rd_idx];

    // apb side
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        cfg_radix = pwdata[RADIX_W-1:0];
        if (cfg_radix < RADIX_MIN) begin
            cfg_radix = RADIX_MIN;
        end else if (cfg_radix > RADIX_MAX) begin
            cfg_radix = RADIX_MAX;
        end
        cfg_order = pwdata[LEN_W-1:0];
        if (cfg_order < ORDER_MIN) begin
            cfg_order = ORDER_MIN;
        end else if (cfg_order > ORDER_MAX) begin
            cfg_order = ORDER_MAX;
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_RADIX: prdata = APB_DW'(r_radix);
            REG_ORDER: prdata = APB_DW'(r_order);
            default:   prdata = '0;
        endcase
    end

    // stream side
    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    // shared unit: add, compare-subtract, multiply by radix and add, radix nibble step
    always_comb begin
        logic [ACC_W:0]           diff;
        logic [ACC_W+RADIX_W-1:0] prod;
        logic [8:0]               part;
        logic [8:0]               dsh;
        logic [SYM_W-1:0]         qd;
        diff = {1'b0, alu_a} - {1'b0, alu_b};
        prod = (ACC_W+RADIX_W)'(alu_a) * (ACC_W+RADIX_W)'(r_radix);
        part = {1'b0, alu_a[7:0]};
        qd   = '0;
        // restoring divide of an 8-bit partial by radix, quotient digit below 16
        for (int k = SYM_W - 1; k >= 0; k--) begin
            dsh = 9'(r_radix) << k;
            if (part >= dsh) begin
                part  = part - dsh;
                qd[k] = 1'b1;
            end
        end
        alu_borrow = diff[ACC_W];
        case (alu_op)
            ALU_ADD: alu_y = alu_a + alu_b;
            ALU_SUB: alu_y = diff[ACC_W-1:0];
            ALU_MAC: alu_y = prod[ACC_W-1:0] + alu_b;
            ALU_DIV: alu_y = ACC_W'({part[SYM_W-1:0], qd});
            default: alu_y = '0;
        endcase
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_radix   = r_radix;
        n_order   = r_order;
        n_wv      = r_wv;
        n_wlen    = r_wlen;
        n_total   = r_total;
        n_acc     = r_acc;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_nib     = r_nib;
        n_bit     = r_bit;
        n_item    = r_item;
        n_res     = r_res;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        rd_idx    = '0;
        wr_idx    = r_cnt;
        pow_we    = 1'b0;
        off_we    = 1'b0;
        pow_wdata = alu_y[CODE_W-1:0];
        off_wdata = alu_y[CODE_W-1:0];
        alu_op    = ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;

        // result beat taken downstream
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            // level tables: pow[k] = pow[k-1]*radix, off[k] = off[k-1] + pow[k-1]
            ST_RB_START: begin
                wr_idx    = '0;
                pow_we    = 1'b1;
                off_we    = 1'b1;
                pow_wdata = CODE_W'(1);
                off_wdata = '0;
                n_cnt     = IDX_W'(1);
                n_state   = ST_RB_MUL;
            end
            ST_RB_MUL: begin
                rd_idx  = r_cnt - IDX_W'(1);
                alu_op  = ALU_MAC;
                alu_a   = ACC_W'(rd_pow);
                pow_we  = 1'b1;
                n_state = ST_RB_ADD;
            end
            ST_RB_ADD: begin
                rd_idx = r_cnt - IDX_W'(1);
                alu_op = ALU_ADD;
                alu_a  = ACC_W'(rd_off);
                alu_b  = ACC_W'(rd_pow);
                off_we = 1'b1;
                if (r_cnt == IDX_MAX) begin
                    n_state = ST_RB_TOT;
                end else begin
                    n_cnt   = r_cnt + IDX_W'(1);
                    n_state = ST_RB_MUL;
                end
            end
            // count of all codes for the configured order
            ST_RB_TOT: begin
                rd_idx  = IDX_W'(r_order);
                alu_op  = ALU_ADD;
                alu_a   = ACC_W'(rd_off);
                alu_b   = ACC_W'(rd_pow);
                n_total = alu_y[CODE_W-1:0];
                n_state = ST_IDLE;
            end
            // take a request beat and dispatch on its mode
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_item = i_req.payload;
                    n_res  = '0;
                    case (t_mode'(i_req.payload.mode))
                        MODE_PUSH: begin
                            n_acc = ACC_W'(r_wv);
                            if ({1'b0, i_req.payload.base} >= r_radix) begin
                                n_res.error = 1'b1;
                                n_state     = ST_OUT;
                            end else if (r_wlen < r_order) begin
                                n_state = ST_PUSH_MUL;
                            end else begin
                                n_bit   = 2'd3;
                                n_state = ST_SLIDE_MOD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_wv    = '0;
                            n_wlen  = '0;
                            n_state = ST_OUT;
                        end
                        MODE_DECODE: begin
                            n_state = ST_DEC_CHK;
                        end
                        default: begin
                            n_res.error = 1'b1;
                            n_state     = ST_OUT;
                        end
                    endcase
                end
            end
            // drop the oldest symbol: window mod radix^(order-1)
            ST_SLIDE_MOD: begin
                rd_idx = IDX_W'(r_order - 4'd1);
                alu_op = ALU_SUB;
                alu_a  = r_acc;
                alu_b  = ACC_W'(rd_pow) << r_bit;
                if (!alu_borrow) begin
                    n_acc = alu_y;
                end
                if (r_bit == 2'd0) begin
                    n_state = ST_PUSH_MUL;
                end else begin
                    n_bit = r_bit - 2'd1;
                end
            end
            // shift the new base into the window
            ST_PUSH_MUL: begin
                alu_op = ALU_MAC;
                alu_a  = r_acc;
                alu_b  = ACC_W'(r_item.base);
                n_wv   = alu_y[WIN_W-1:0];
                if (r_wlen < r_order) begin
                    n_wlen = r_wlen + 4'd1;
                end
                n_state = ST_PUSH_OFF;
            end
            ST_PUSH_OFF: begin
                rd_idx         = IDX_W'(r_wlen);
                alu_op         = ALU_ADD;
                alu_a          = ACC_W'(r_wv);
                alu_b          = ACC_W'(rd_off);
                n_res.code_out = alu_y[CODE_W-1:0];
                n_res.length   = r_wlen;
                n_state        = ST_OUT;
            end
            // decode: range check against the total count
            ST_DEC_CHK: begin
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(r_item.code_in);
                alu_b  = ACC_W'(r_total);
                if (!alu_borrow) begin
                    n_res.error = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    n_len   = '0;
                    n_state = ST_DEC_LEN;
                end
            end
            // level search, one offset compare a cycle
            ST_DEC_LEN: begin
                if (r_len < r_order) begin
                    rd_idx = IDX_W'(r_len + 4'd1);
                    alu_op = ALU_SUB;
                    alu_a  = ACC_W'(r_item.code_in);
                    alu_b  = ACC_W'(rd_off);
                    if (!alu_borrow) begin
                        n_len = r_len + 4'd1;
                    end else begin
                        n_state = ST_DEC_SUB;
                    end
                end else begin
                    n_state = ST_DEC_SUB;
                end
            end
            // window value of the decoded k-mer
            ST_DEC_SUB: begin
                rd_idx = IDX_W'(r_len);
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(r_item.code_in);
                alu_b  = ACC_W'(rd_off);
                n_acc  = alu_y;
                n_quo  = alu_y[WIN_W-1:0];
                n_rem  = '0;
                n_nib  = NIB_LAST;
                if (r_len == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DEC_DIV;
                end
            end
            // long division by radix, one nibble a cycle, msb first
            ST_DEC_DIV: begin
                alu_op = ALU_DIV;
                alu_a  = ACC_W'({r_rem, r_quo[WIN_W-1 -: SYM_W]});
                n_quo  = {r_quo[WIN_W-SYM_W-1:0], alu_y[SYM_W-1:0]};
                n_rem  = alu_y[2*SYM_W-1:SYM_W];
                if (r_nib == '0) begin
                    n_state = ST_DEC_PRE;
                end else begin
                    n_nib = r_nib - NIB_W'(1);
                end
            end
            ST_DEC_PRE: begin
                rd_idx            = IDX_W'(r_len - 4'd1);
                alu_op            = ALU_ADD;
                alu_a             = ACC_W'(r_quo);
                alu_b             = ACC_W'(rd_off);
                n_res.prefix_code = alu_y[CODE_W-1:0];
                n_bit             = 2'd3;
                n_state           = ST_DEC_MOD;
            end
            // strip the first symbol: value mod radix^(len-1)
            ST_DEC_MOD: begin
                rd_idx = IDX_W'(r_len - 4'd1);
                alu_op = ALU_SUB;
                alu_a  = r_acc;
                alu_b  = ACC_W'(rd_pow) << r_bit;
                if (!alu_borrow) begin
                    n_acc = alu_y;
                end
                if (r_bit == 2'd0) begin
                    n_state = ST_DEC_SUF;
                end else begin
                    n_bit = r_bit - 2'd1;
                end
            end
            ST_DEC_SUF: begin
                rd_idx            = IDX_W'(r_len - 4'd1);
                alu_op            = ALU_ADD;
                alu_a             = r_acc;
                alu_b             = ACC_W'(rd_off);
                n_res.suffix_code = alu_y[CODE_W-1:0];
                n_res.length      = r_len;
                n_res.last_base   = r_rem;
                n_state           = ST_OUT;
            end
            // hand the result to the output register once it is free
            ST_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_RB_START;
            end
        endcase

        // register write: saturate, empty the window, rebuild the tables
        if (cfg_we) begin
            case (t_reg_idx'(paddr[2]))
                REG_RADIX: n_radix = cfg_radix;
                REG_ORDER: n_order = cfg_order;
                default:   n_radix = r_radix;
            endcase
            n_wv    = '0;
            n_wlen  = '0;
            n_state = ST_RB_START;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RB_START;
            r_radix  <= RADIX_RST;
            r_order  <= ORDER_RST;
            r_wv     <= '0;
            r_wlen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_radix  <= n_radix;
            r_order  <= n_order;
            r_wv     <= n_wv;
            r_wlen   <= n_wlen;
            r_ovalid <= n_ovalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_len   <= n_len;
        r_cnt   <= n_cnt;
        r_nib   <= n_nib;
        r_bit   <= n_bit;
        r_item  <= n_item;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // level tables, one entry of each per cycle
    always_ff @(posedge i_clk) begin
        if (pow_we) begin
            r_pow[wr_idx] <= pow_wdata;
        end
        if (off_we) begin
            r_off[wr_idx] <= off_wdata;
        end
    end

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wlen <= r_order)
        else $error("window length above order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> (r_state == ST_RB_START && r_wlen == '0))
        else $error("register write did not restart table rebuild");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEC_DIV || r_state == ST_DEC_PRE) |-> ({1'b0, r_rem} < r_radix))
        else $error("division remainder not below radix");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.error) |-> (r_out.code_out == '0 && r_out.length == '0
            && r_out.last_base == '0 && r_out.prefix_code == '0
            && r_out.suffix_code == '0))
        else $error("error beat carries nonzero fields");

endmodule
